// ----- rtl/ewmaz_pkg.sv -----
// Shared types and constants for the EWMA z-score anomaly detector.
package ewmaz_pkg;

   localparam int unsigned CFG_W = 17;
   localparam int unsigned CSR_ADDR_W = 3;

   localparam logic [CSR_ADDR_W-1:0] CSR_ENABLE   = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_ALPHA    = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_MIN_SMP  = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_Z_LIMIT  = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_COOLDOWN = 3'd4;

   localparam logic [16:0] ONE_Q16 = 17'h10000;

   // divider shape: 50-bit dividend (d2 or df<<16), 33-bit divisor (var or dt)
   localparam int unsigned DIV_NUM_W = 50;
   localparam int unsigned DIV_DEN_W = 33;
   localparam int unsigned SQRT_TOP  = 14;

   typedef struct packed {
      logic [31:0] total_requests;
      logic [31:0] failed_requests;
   } req_type;

   typedef struct packed {
      logic [16:0]        interval_rate;
      logic [16:0]        baseline_mean;
      logic signed [15:0] z_score;
      logic               is_anomaly;
      logic               raise_alert;
   } rsp_type;

   typedef struct packed {
      logic        anomaly_enable;
      logic [16:0] smoothing_alpha;
      logic [15:0] min_samples;
      logic [15:0] z_limit;
      logic [15:0] cooldown_intervals;
   } cfg_type;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_LOAD,
      OP_ZERO,
      OP_RATE_GO,
      OP_RATE_END,
      OP_FIRST,
      OP_MAG,
      OP_Z_GO,
      OP_Z_END,
      OP_SQRT,
      OP_U1,
      OP_U2,
      OP_U3,
      OP_U4,
      OP_U5,
      OP_U6
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [3:0] sqrt_idx;
      logic       rsp_load;
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic first_sample;
   } sts_type;

endpackage

// ----- rtl/ewmaz_div.sv -----
// Restoring divider, one quotient bit per cycle.
module ewmaz_div #(
   parameter int unsigned NUM_W = 50,
   parameter int unsigned DEN_W = 33
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             done,
   output logic [NUM_W-1:0] quot
);

   localparam int unsigned CNT_W = $clog2(NUM_W + 1);
   localparam logic [CNT_W-1:0] LAST = CNT_W'(NUM_W - 1);

   logic [NUM_W-1:0] num_ff, num_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff, done_ff;
   logic [DEN_W:0]   shifted;
   logic             ge;

   assign shifted = {rem_ff, num_ff[NUM_W-1]};
   assign ge      = shifted >= {1'b0, den_ff};
   assign rem_in  = ge ? DEN_W'(shifted - {1'b0, den_ff}) : shifted[DEN_W-1:0];
   assign num_in  = {num_ff[NUM_W-2:0], ge};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == LAST) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         num_ff <= num;
         rem_ff <= '0;
         den_ff <= den;
      end else if (busy_ff) begin
         num_ff <= num_in;
         rem_ff <= rem_in;
      end
   end

   assign done = done_ff;
   assign quot = num_ff;

endmodule

// ----- rtl/ewmaz_dp.sv -----
// Datapath: detector state, rate and z-score arithmetic, result registers.
module ewmaz_dp (
   input  logic              clock,
   input  logic              reset,
   input  ewmaz_pkg::cfg_type cfg,
   input  ewmaz_pkg::req_type req_data,
   input  ewmaz_pkg::cmd_type cmd,
   output ewmaz_pkg::sts_type sts,
   output ewmaz_pkg::rsp_type rsp_data
);

   localparam int unsigned NW = ewmaz_pkg::DIV_NUM_W;
   localparam int unsigned DW = ewmaz_pkg::DIV_DEN_W;

   // architectural state
   logic [31:0] prev_total_ff, prev_failed_ff;
   logic [15:0] count_ff;
   logic [16:0] mean_ff;
   logic [32:0] var_ff;
   logic        alerted_ff;
   logic [15:0] isa_ff;

   // working registers
   logic [31:0] total_ff, failed_ff;
   logic [16:0] rate_ff, mag_ff, mean_new_ff;
   logic        neg_ff, anom_ff;
   logic [33:0] msq_ff, pa_ff, t_ff;
   logic [50:0] pc_ff, pd_ff;
   logic [NW-1:0] quot_ff;
   logic [15:0] q_ff;
   logic [15:0] zout_ff;
   ewmaz_pkg::rsp_type res_ff, rsp_ff;

   logic [31:0]   dt, df;
   logic [16:0]   alpha, nalpha;
   logic          div_go, div_done;
   logic [NW-1:0] div_num, div_quot;
   logic [DW-1:0] div_den, var_floor;
   logic [33:0]   mag_sq;
   logic [15:0]   cand, zmag, need, count_inc, isa_inc;
   logic [31:0]   cand_sq, lim;
   logic          big;
   logic [34:0]   mean_sum;
   logic [51:0]   t_sum;
   logic [51:0]   v_round;
   logic          alert;

   assign dt        = total_ff - prev_total_ff;
   assign df        = failed_ff - prev_failed_ff;
   assign alpha     = (cfg.smoothing_alpha > ewmaz_pkg::ONE_Q16) ?
                      ewmaz_pkg::ONE_Q16 : cfg.smoothing_alpha;
   assign nalpha    = ewmaz_pkg::ONE_Q16 - alpha;
   assign var_floor = (var_ff == '0) ? DW'(1) : var_ff;
   assign mag_sq    = 34'(mag_ff) * 34'(mag_ff);

   assign div_go  = (cmd.op == ewmaz_pkg::OP_RATE_GO) || (cmd.op == ewmaz_pkg::OP_Z_GO);
   assign div_num = (cmd.op == ewmaz_pkg::OP_Z_GO) ? {mag_sq, 16'd0} :
                    NW'({df, 16'd0});
   assign div_den = (cmd.op == ewmaz_pkg::OP_Z_GO) ? var_floor : {1'b0, dt};

   ewmaz_div #(.NUM_W(NW), .DEN_W(DW)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_go),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quot  (div_quot)
   );

   assign cand      = q_ff | (16'd1 << cmd.sqrt_idx);
   assign cand_sq   = 32'(cand) * 32'(cand);
   assign big       = quot_ff >= NW'(64'h4000_0000);
   assign zmag      = big ? 16'h8000 : q_ff;
   assign need      = (cfg.min_samples == '0) ? 16'd1 : cfg.min_samples;
   assign count_inc = (count_ff == 16'hFFFF) ? count_ff : count_ff + 16'd1;
   assign isa_inc   = (isa_ff == 16'hFFFF) ? isa_ff : isa_ff + 16'd1;
   assign lim       = 32'(cfg.z_limit) * 32'(cfg.z_limit);
   assign mean_sum  = 35'(pa_ff) + 35'(34'(alpha) * 34'(rate_ff)) + 35'd32768;
   assign t_sum     = 52'(var_ff) + ((52'(pc_ff) + 52'd32768) >> 16);
   assign v_round   = (52'(pd_ff) + 52'd32768) >> 16;
   assign alert     = anom_ff && (!alerted_ff || isa_inc >= cfg.cooldown_intervals);

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_total_ff  <= '0;
         prev_failed_ff <= '0;
         count_ff       <= '0;
         mean_ff        <= '0;
         var_ff         <= '0;
         alerted_ff     <= 1'b0;
         isa_ff         <= '0;
      end else begin
         case (cmd.op)
            ewmaz_pkg::OP_FIRST: begin
               prev_total_ff  <= total_ff;
               prev_failed_ff <= failed_ff;
               count_ff       <= 16'd1;
               mean_ff        <= rate_ff;
               var_ff         <= '0;
               isa_ff         <= isa_inc;
            end
            ewmaz_pkg::OP_U6: begin
               prev_total_ff  <= total_ff;
               prev_failed_ff <= failed_ff;
               count_ff       <= count_inc;
               mean_ff        <= mean_new_ff;
               var_ff         <= (v_round > 52'h1_0000_0000) ? 33'h1_0000_0000 :
                                 v_round[32:0];
               if (alert) begin
                  alerted_ff <= 1'b1;
                  isa_ff     <= '0;
               end else begin
                  isa_ff <= isa_inc;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case (cmd.op)
         ewmaz_pkg::OP_LOAD: begin
            total_ff  <= req_data.total_requests;
            failed_ff <= req_data.failed_requests;
         end
         ewmaz_pkg::OP_ZERO: begin
            res_ff <= '0;
         end
         ewmaz_pkg::OP_RATE_END: begin
            if (dt == '0)
               rate_ff <= '0;
            else if (div_quot > NW'(ewmaz_pkg::ONE_Q16))
               rate_ff <= ewmaz_pkg::ONE_Q16;
            else
               rate_ff <= div_quot[16:0];
         end
         ewmaz_pkg::OP_FIRST: begin
            res_ff <= '{interval_rate: rate_ff, baseline_mean: mean_ff,
                        z_score: '0, is_anomaly: 1'b0, raise_alert: 1'b0};
         end
         ewmaz_pkg::OP_MAG: begin
            neg_ff <= rate_ff < mean_ff;
            mag_ff <= (rate_ff < mean_ff) ? mean_ff - rate_ff : rate_ff - mean_ff;
            q_ff   <= '0;
         end
         ewmaz_pkg::OP_Z_GO: begin
            msq_ff <= mag_sq;
         end
         ewmaz_pkg::OP_Z_END: begin
            quot_ff <= div_quot;
         end
         ewmaz_pkg::OP_SQRT: begin
            if (NW'(cand_sq) <= quot_ff) q_ff <= cand;
         end
         ewmaz_pkg::OP_U1: begin
            if (neg_ff)
               zout_ff <= 16'(17'h10000 - 17'(zmag));
            else
               zout_ff <= (zmag > 16'd32767) ? 16'd32767 : zmag;
            anom_ff <= (count_inc >= need) && (quot_ff >= NW'(lim));
            pa_ff   <= 34'(nalpha) * 34'(mean_ff);
         end
         ewmaz_pkg::OP_U2: begin
            mean_new_ff <= mean_sum[32:16];
         end
         ewmaz_pkg::OP_U3: begin
            pc_ff <= 51'(alpha) * 51'(msq_ff);
         end
         ewmaz_pkg::OP_U4: begin
            t_ff <= t_sum[33:0];
         end
         ewmaz_pkg::OP_U5: begin
            pd_ff <= 51'(nalpha) * 51'(t_ff);
         end
         ewmaz_pkg::OP_U6: begin
            res_ff <= '{interval_rate: rate_ff, baseline_mean: mean_ff,
                        z_score: zout_ff, is_anomaly: anom_ff, raise_alert: alert};
         end
         default: begin
         end
      endcase
      if (cmd.rsp_load) rsp_ff <= res_ff;
   end

   assign sts.div_done     = div_done;
   assign sts.first_sample = count_ff == '0;
   assign rsp_data         = rsp_ff;

endmodule

// ----- rtl/ewmaz_ctrl.sv -----
// Controller: sequences one word through rate, z-score and EWMA update steps.
module ewmaz_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               enable,
   input  logic               req_valid,
   output logic               req_stall,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   input  ewmaz_pkg::sts_type sts,
   output ewmaz_pkg::cmd_type cmd
);

   typedef enum logic [4:0] {
      S_IDLE, S_ZERO, S_RATE_GO, S_RATE_WAIT, S_FIRST, S_MAG, S_Z_GO, S_Z_WAIT,
      S_SQRT, S_U1, S_U2, S_U3, S_U4, S_U5, S_U6, S_OUT
   } state_type;

   state_type  state_ff, state_in;
   logic [3:0] idx_ff, idx_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       load;

   assign req_stall = state_ff != S_IDLE;
   assign load      = (state_ff == S_OUT) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      cmd.op       = ewmaz_pkg::OP_NONE;
      cmd.sqrt_idx = idx_ff;
      cmd.rsp_load = load;
      rsp_valid_in = load || (rsp_valid_ff && rsp_stall);
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.op   = ewmaz_pkg::OP_LOAD;
               state_in = enable ? S_RATE_GO : S_ZERO;
            end
         end
         S_ZERO: begin
            cmd.op   = ewmaz_pkg::OP_ZERO;
            state_in = S_OUT;
         end
         S_RATE_GO: begin
            cmd.op   = ewmaz_pkg::OP_RATE_GO;
            state_in = S_RATE_WAIT;
         end
         S_RATE_WAIT: begin
            if (sts.div_done) begin
               cmd.op   = ewmaz_pkg::OP_RATE_END;
               state_in = sts.first_sample ? S_FIRST : S_MAG;
            end
         end
         S_FIRST: begin
            cmd.op   = ewmaz_pkg::OP_FIRST;
            state_in = S_OUT;
         end
         S_MAG: begin
            cmd.op   = ewmaz_pkg::OP_MAG;
            state_in = S_Z_GO;
         end
         S_Z_GO: begin
            cmd.op   = ewmaz_pkg::OP_Z_GO;
            state_in = S_Z_WAIT;
         end
         S_Z_WAIT: begin
            if (sts.div_done) begin
               cmd.op   = ewmaz_pkg::OP_Z_END;
               idx_in   = 4'(ewmaz_pkg::SQRT_TOP);
               state_in = S_SQRT;
            end
         end
         S_SQRT: begin
            cmd.op = ewmaz_pkg::OP_SQRT;
            if (idx_ff == '0) state_in = S_U1;
            else idx_in = idx_ff - 4'd1;
         end
         S_U1: begin
            cmd.op   = ewmaz_pkg::OP_U1;
            state_in = S_U2;
         end
         S_U2: begin
            cmd.op   = ewmaz_pkg::OP_U2;
            state_in = S_U3;
         end
         S_U3: begin
            cmd.op   = ewmaz_pkg::OP_U3;
            state_in = S_U4;
         end
         S_U4: begin
            cmd.op   = ewmaz_pkg::OP_U4;
            state_in = S_U5;
         end
         S_U5: begin
            cmd.op   = ewmaz_pkg::OP_U5;
            state_in = S_U6;
         end
         S_U6: begin
            cmd.op   = ewmaz_pkg::OP_U6;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (load) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- rtl/ewma_zscore_anomaly_detector.sv -----
// Top level: EWMA z-score anomaly detector on interval error rate.
// A word taken while disabled gets a zero result; the first sample runs one 50-step
// division for the rate; later words run two 50-step divisions, a 15-step square root
// and six update steps. One word in flight; the next word is taken the cycle after the
// result loads into the output register, and that load waits while rsp_stall holds an
// earlier result.
// Reset (synchronous) clears detector state and returns the configuration registers to their defaults.
module ewma_zscore_anomaly_detector (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  ewmaz_pkg::req_type                   req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output ewmaz_pkg::rsp_type                   rsp_data,
   input  logic                                 csr_wr_en,
   input  logic [ewmaz_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [ewmaz_pkg::CFG_W-1:0]          csr_wr_data
);

   ewmaz_pkg::cfg_type cfg_ff;
   ewmaz_pkg::cmd_type cmd;
   ewmaz_pkg::sts_type sts;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{anomaly_enable: 1'b0, smoothing_alpha: 17'd6554, min_samples: 16'd10,
                     z_limit: 16'd768, cooldown_intervals: 16'd0};
      end else if (csr_wr_en) begin
         case (csr_addr)
            ewmaz_pkg::CSR_ENABLE:   cfg_ff.anomaly_enable     <= csr_wr_data[0];
            ewmaz_pkg::CSR_ALPHA:    cfg_ff.smoothing_alpha    <= csr_wr_data;
            ewmaz_pkg::CSR_MIN_SMP:  cfg_ff.min_samples        <= csr_wr_data[15:0];
            ewmaz_pkg::CSR_Z_LIMIT:  cfg_ff.z_limit            <= csr_wr_data[15:0];
            ewmaz_pkg::CSR_COOLDOWN: cfg_ff.cooldown_intervals <= csr_wr_data[15:0];
            default: begin
            end
         endcase
      end
   end

   ewmaz_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .enable    (cfg_ff.anomaly_enable),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   ewmaz_dp u_dp (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .req_data (req_data),
      .cmd      (cmd),
      .sts      (sts),
      .rsp_data (rsp_data)
   );

endmodule

// ----- rtl/ewmaz_chk.sv -----
// Port-level checks for the anomaly detector, bound to the top level.
module ewmaz_chk (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input ewmaz_pkg::rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result word dropped or changed while stalled");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second word taken while one is in work");

   a_alert_needs_anomaly: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !rsp_data.raise_alert || rsp_data.is_anomaly)
      else $error("alert without anomaly");

   a_rate_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.interval_rate <= ewmaz_pkg::ONE_Q16 &&
                    rsp_data.baseline_mean <= ewmaz_pkg::ONE_Q16)
      else $error("rate or mean above 1.0");

endmodule

bind ewma_zscore_anomaly_detector ewmaz_chk u_chk (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

// ----- dv/ewmaz_checker.sv -----
// Checker for the EWMA z-score anomaly detector: watches both channels, predicts, compares.
module ewmaz_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_stall,
   input  ewmaz_pkg::req_type                  req_data,
   input  logic                                rsp_valid,
   input  logic                                rsp_stall,
   input  ewmaz_pkg::rsp_type                  rsp_data,
   input  logic                                csr_wr_en,
   input  logic [ewmaz_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  logic [ewmaz_pkg::CFG_W-1:0]         csr_wr_data,
   output int                                  err_count,
   output int                                  pending,
   output int                                  rsp_count,
   output int                                  anomaly_count,
   output int                                  alert_count
);
   timeunit 1ns;
   timeprecision 1ps;

   ewmaz_pkg::cfg_type cfg;
   logic [31:0]        last_total, last_failed;
   logic [15:0]        n_samples, since_alert;
   logic [16:0]        mean_q16;
   logic [32:0]        var_q32;
   logic               alerted;
   ewmaz_pkg::rsp_type expected_q[$];

   function automatic ewmaz_pkg::rsp_type score_interval(ewmaz_pkg::req_type w);
      logic [31:0] dt, df;
      logic [16:0] rate, base;
      logic [63:0] quot, mag, v, d2, lim, t;
      int unsigned a, na, lo, hi, mid, need;
      logic        neg, anom;
      ewmaz_pkg::rsp_type o;
      o = '0;
      anom = 1'b0;
      if (!cfg.anomaly_enable) return o;
      dt = w.total_requests - last_total;
      df = w.failed_requests - last_failed;
      if (dt == 0) rate = '0;
      else begin
         quot = {16'b0, df, 16'b0} / {32'b0, dt};
         rate = (quot > 64'd65536) ? ewmaz_pkg::ONE_Q16 : quot[16:0];
      end
      last_total = w.total_requests;
      last_failed = w.failed_requests;
      base = mean_q16;
      if (since_alert < 16'hFFFF) since_alert++;
      if (n_samples == 0) begin
         n_samples = 16'd1;
         mean_q16 = rate;
         var_q32 = '0;
      end else begin
         a = (cfg.smoothing_alpha > 17'd65536) ? 65536 : cfg.smoothing_alpha;
         na = 65536 - a;
         neg = rate < base;
         mag = neg ? 64'(base - rate) : 64'(rate - base);
         v = (var_q32 == 0) ? 64'd1 : 64'(var_q32);
         d2 = (mag << 8) * (mag << 8);
         lim = 64'(cfg.z_limit) * 64'(cfg.z_limit);
         // largest magnitude q with q*q*var <= d2
         lo = 0;
         hi = 32768;
         while (lo < hi) begin
            mid = (lo + hi + 1) / 2;
            if (64'(mid) * 64'(mid) * v <= d2) lo = mid;
            else hi = mid - 1;
         end
         if (neg) o.z_score = 16'(32'h10000 - lo);
         else o.z_score = (lo > 32767) ? 16'h7FFF : 16'(lo);
         mean_q16 = 17'((64'(na) * base + 64'(a) * rate + 64'd32768) >> 16);
         t = 64'(var_q32) + ((64'(a) * mag * mag + 64'd32768) >> 16);
         t = (64'(na) * t + 64'd32768) >> 16;
         var_q32 = (t > 64'h1_0000_0000) ? 33'h1_0000_0000 : t[32:0];
         if (n_samples < 16'hFFFF) n_samples++;
         need = (cfg.min_samples == 0) ? 1 : cfg.min_samples;
         anom = (n_samples >= need) && (d2 >= lim * v);
      end
      if (anom && (!alerted || since_alert >= cfg.cooldown_intervals)) begin
         o.raise_alert = 1'b1;
         alerted = 1'b1;
         since_alert = '0;
      end
      o.interval_rate = rate;
      o.baseline_mean = base;
      o.is_anomaly = anom;
      return o;
   endfunction

   assign pending = expected_q.size();

   always @(posedge clock) begin
      ewmaz_pkg::rsp_type e;
      if (reset) begin
         cfg = '{anomaly_enable: 1'b0, smoothing_alpha: 17'd6554, min_samples: 16'd10,
                 z_limit: 16'd768, cooldown_intervals: 16'd0};
         last_total = '0;
         last_failed = '0;
         n_samples = '0;
         since_alert = '0;
         mean_q16 = '0;
         var_q32 = '0;
         alerted = 1'b0;
         expected_q.delete();
         err_count = 0;
         rsp_count = 0;
         anomaly_count = 0;
         alert_count = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_q.size() == 0) begin
               $display("%0t: unexpected result word %p", $time, rsp_data);
               err_count++;
            end else begin
               e = expected_q.pop_front();
               rsp_count++;
               if (rsp_data.is_anomaly) anomaly_count++;
               if (rsp_data.raise_alert) alert_count++;
               if (rsp_data.interval_rate !== e.interval_rate) begin
                  $display("%0t: interval_rate exp %0d got %0d", $time,
                           e.interval_rate, rsp_data.interval_rate);
                  err_count++;
               end
               if (rsp_data.baseline_mean !== e.baseline_mean) begin
                  $display("%0t: baseline_mean exp %0d got %0d", $time,
                           e.baseline_mean, rsp_data.baseline_mean);
                  err_count++;
               end
               if (rsp_data.z_score !== e.z_score) begin
                  $display("%0t: z_score exp %0d got %0d", $time,
                           e.z_score, rsp_data.z_score);
                  err_count++;
               end
               if (rsp_data.is_anomaly !== e.is_anomaly) begin
                  $display("%0t: is_anomaly exp %0b got %0b", $time,
                           e.is_anomaly, rsp_data.is_anomaly);
                  err_count++;
               end
               if (rsp_data.raise_alert !== e.raise_alert) begin
                  $display("%0t: raise_alert exp %0b got %0b", $time,
                           e.raise_alert, rsp_data.raise_alert);
                  err_count++;
               end
            end
         end
         if (req_valid && !req_stall) expected_q = {expected_q, score_interval(req_data)};
         if (csr_wr_en) begin
            case (csr_addr)
               ewmaz_pkg::CSR_ENABLE:   cfg.anomaly_enable = csr_wr_data[0];
               ewmaz_pkg::CSR_ALPHA:    cfg.smoothing_alpha = csr_wr_data[16:0];
               ewmaz_pkg::CSR_MIN_SMP:  cfg.min_samples = csr_wr_data[15:0];
               ewmaz_pkg::CSR_Z_LIMIT:  cfg.z_limit = csr_wr_data[15:0];
               ewmaz_pkg::CSR_COOLDOWN: cfg.cooldown_intervals = csr_wr_data[15:0];
               default: ;
            endcase
         end
      end
   end

endmodule

// ----- dv/ewma_zscore_anomaly_detector_tb.sv -----
// Testbench top for the EWMA z-score anomaly detector: stimulus, flow control and verdict.
module ewma_zscore_anomaly_detector_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 5000000;
   localparam int HOLD_CYCLES = 800;

   logic                                clock, reset;
   logic                                req_valid, req_stall;
   ewmaz_pkg::req_type                  req_data;
   logic                                rsp_valid, rsp_stall;
   ewmaz_pkg::rsp_type                  rsp_data;
   logic                                csr_wr_en;
   logic [ewmaz_pkg::CSR_ADDR_W-1:0]    csr_addr;
   logic [ewmaz_pkg::CFG_W-1:0]         csr_wr_data;

   int          err_count, pending, rsp_count, anomaly_count, alert_count;
   int          cycles, words_sent;
   bit          hold_req;
   logic [31:0] cum_total, cum_failed;
   int unsigned base_frac;

   ewma_zscore_anomaly_detector dut (.*);

   ewmaz_checker chk (.*);

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // receiver: random stalls, quiet stretches, one long hold on request
   initial begin
      int r, len;
      logic s;
      rsp_stall = 1'b0;
      @(negedge reset);
      forever begin
         if (hold_req) begin
            hold_req = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            r = $urandom_range(0, 99);
            s = (r < 35);
            if (r < 4) len = $urandom_range(30, 200);
            else if (r >= 92) len = $urandom_range(100, 400);
            else len = $urandom_range(1, 4);
            rsp_stall <= s;
            repeat (len) @(posedge clock);
         end
      end
   end

   task automatic write_reg(input logic [ewmaz_pkg::CSR_ADDR_W-1:0] a,
                            input logic [ewmaz_pkg::CFG_W-1:0] d);
      csr_wr_en <= 1'b1;
      csr_addr <= a;
      csr_wr_data <= d;
      @(posedge clock);
   endtask

   task automatic write_cfg(input ewmaz_pkg::cfg_type c);
      write_reg(ewmaz_pkg::CSR_ENABLE, ewmaz_pkg::CFG_W'(c.anomaly_enable));
      write_reg(ewmaz_pkg::CSR_ALPHA, c.smoothing_alpha);
      write_reg(ewmaz_pkg::CSR_MIN_SMP, ewmaz_pkg::CFG_W'(c.min_samples));
      write_reg(ewmaz_pkg::CSR_Z_LIMIT, ewmaz_pkg::CFG_W'(c.z_limit));
      write_reg(ewmaz_pkg::CSR_COOLDOWN, ewmaz_pkg::CFG_W'(c.cooldown_intervals));
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   // stop offering, let the checker see the last accept, then wait for every result
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic push(input logic [31:0] tot, input logic [31:0] fail, input int gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= '{total_requests: tot, failed_requests: fail};
      do @(posedge clock); while (req_stall);
      words_sent++;
   endtask

   task automatic push_delta(input logic [31:0] dt, input logic [31:0] df);
      int r, gap;
      cum_total += dt;
      cum_failed += df;
      r = $urandom_range(0, 99);
      if (r < 45) gap = 0;
      else if (r < 92) gap = $urandom_range(1, 8);
      else gap = $urandom_range(20, 300);
      push(cum_total, cum_failed, gap);
   endtask

   // one interval: mostly a jittered steady rate, with spikes, dips and odd counters
   task automatic random_interval();
      int r;
      logic [31:0] dt, df;
      logic [63:0] p;
      r = $urandom_range(0, 99);
      dt = $urandom_range(1000, 200000);
      p = 64'(dt) * base_frac;
      df = 32'(p >> 16) + $urandom_range(0, 40);
      if (df > dt) df = dt;
      if (r < 5) df = 32'((64'(dt) * $urandom_range(0, 65536)) >> 16);
      else if (r < 8) dt = 0;
      else if (r < 10) df = dt + $urandom_range(1, 100000);
      else if (r < 12) begin
         dt = $urandom;
         df = $urandom;
      end else if (r < 13) begin
         dt = $urandom_range(1, 4);
         df = $urandom_range(0, 4);
      end
      push_delta(dt, df);
   endtask

   function automatic ewmaz_pkg::cfg_type phase_cfg(input int ph);
      ewmaz_pkg::cfg_type c;
      c.anomaly_enable = ($urandom_range(0, 9) != 0);
      case ($urandom_range(0, 4))
         0: c.smoothing_alpha = 17'($urandom_range(1, 2000));
         1: c.smoothing_alpha = 17'($urandom_range(2000, 20000));
         default: c.smoothing_alpha = 17'($urandom_range(0, 131071));
      endcase
      c.min_samples = 16'($urandom_range(0, 30));
      c.z_limit = 16'($urandom_range(0, 2000));
      c.cooldown_intervals = 16'($urandom_range(0, 20));
      case (ph)
         0: c = '{1'b1, 17'd0, 16'd0, 16'd0, 16'd0};
         1: c = '{1'b1, 17'd65536, 16'd1, 16'hFFFF, 16'hFFFF};
         2: c = '{1'b1, 17'h1FFFF, 16'hFFFF, 16'd256, 16'd3};
         3: c = '{1'b1, 17'd1, 16'd2, 16'd512, 16'hFFFF};
         4: c.anomaly_enable = 1'b0;
         5: c.z_limit = 16'($urandom_range(0, 65535));
         6: c.min_samples = 16'($urandom_range(0, 65535));
         7: c.cooldown_intervals = 16'($urandom_range(0, 65535));
         default: ;
      endcase
      return c;
   endfunction

   initial begin
      ewmaz_pkg::cfg_type c;
      int n;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_wr_en = 1'b0;
      csr_addr = '0;
      csr_wr_data = '0;
      cycles = 0;
      words_sent = 0;
      hold_req = 1'b0;
      cum_total = '0;
      cum_failed = '0;
      base_frac = 3000;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: disabled at reset, then first sample, extremes and a spike
      push(32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
      push(32'd5, 32'd9, 0);
      drain();
      write_reg(ewmaz_pkg::CSR_ENABLE, ewmaz_pkg::CFG_W'(1));
      write_reg(ewmaz_pkg::CSR_MIN_SMP, ewmaz_pkg::CFG_W'(3));
      csr_wr_en <= 1'b0;
      @(posedge clock);
      cum_total = 32'd5;
      cum_failed = 32'd9;
      push_delta(32'd1000, 32'd10);
      push_delta(32'd0, 32'd7);
      push_delta(32'd100, 32'd500);
      push_delta(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      push_delta(32'd2000, 32'd0);
      push_delta(32'hFFFF_FFF0, 32'h8000_0000);
      for (int i = 0; i < 10; i++) push_delta(32'd1000, 32'd30 + i[31:0] % 3);
      push_delta(32'd1000, 32'd900);
      push_delta(32'd1000, 32'd31);
      push_delta(32'd1000, 32'd0);
      push_delta(32'd1, 32'd1);
      drain();

      for (int ph = 0; ph < 30; ph++) begin
         c = phase_cfg(ph);
         write_cfg(c);
         base_frac = $urandom_range(0, 3) == 0 ? $urandom_range(0, 65536)
                                               : $urandom_range(0, 8000);
         if (ph == 3) hold_req = 1'b1;
         n = (ph < 8) ? 40 : 68;
         for (int i = 0; i < n; i++) random_interval();
         drain();
      end

      while (pending != 0) @(posedge clock);
      repeat (150) @(posedge clock);
      $display("Sent %0d counter words, checked %0d results over 30 register settings.",
               words_sent, rsp_count);
      $display("Saw %0d anomaly flags and %0d alerts.", anomaly_count, alert_count);
      if (err_count == 0 && pending == 0) $display("All tests passed");
      else $display("Some tests failed");
      $finish;
   end

endmodule
